// File: rtl/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared constants for the cubic Bezier point evaluator: default widths,
// register map codes and APB port sizing.
// ----------------------------------------------------------------------------
package cbpe_pkg;

  localparam int T_FRAC_BITS_DEF = 12;
  localparam int COORD_BITS_DEF  = 10;

  // register map, one 32-bit word per register
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;
  localparam int APB_ADDR_W  = REG_IDX_W + 2;
  localparam int APB_DATA_W  = 32;

  localparam logic [REG_IDX_W-1:0] REG_P0_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_P0_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_P1_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_P1_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_P2_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_P2_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_P3_X = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_P3_Y = 3'd7;

  // control point array indexing
  localparam int NUM_PTS = 4;
  localparam int NUM_AX  = 2;
  localparam int AX_X    = 0;
  localparam int AX_Y    = 1;

  // pipeline depth: saturate, three levels of multiply then add
  localparam int NUM_STAGES = 7;

endpackage

// File: rtl/cubic_bezier_point_eval.sv
// Throughput one request per cycle while out_ready lets the output drain, set by
// the seven-stage pipeline: a saturate stage, then one multiply stage and one add
// stage per de Casteljau level. A stall holds each full stage in place.
// Reset (rst, synchronous) clears all stage valid bits and sets the four
// control points to zero.
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval
// Exact cubic Bezier evaluation in fixed point: three levels of de Casteljau
// interpolation kept at full precision, result floored to integer pixels.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval
  import cbpe_pkg::*;
#(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [T_FRAC_BITS:0]   t_param,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_BITS-1:0]  pixel_x,
  output logic [COORD_BITS-1:0]  pixel_y
);

  localparam int TW  = T_FRAC_BITS + 1;
  localparam int C   = COORD_BITS;
  localparam int T   = T_FRAC_BITS;
  localparam int W1  = C + T;
  localparam int W1P = C + T + 1;
  localparam int W2  = C + 2 * T;
  localparam int W2P = C + 2 * T + 1;
  localparam int W3  = C + 3 * T;
  localparam int W3P = C + 3 * T + 1;

  localparam logic [TW-1:0] T_ONE = {1'b1, {T{1'b0}}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [C-1:0]         pt [NUM_PTS][NUM_AX];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PTS; p++) begin
        for (int a = 0; a < NUM_AX; a++) begin
          pt[p][a] <= '0;
        end
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_P0_X: pt[0][AX_X] <= pwdata[C-1:0];
        REG_P0_Y: pt[0][AX_Y] <= pwdata[C-1:0];
        REG_P1_X: pt[1][AX_X] <= pwdata[C-1:0];
        REG_P1_Y: pt[1][AX_Y] <= pwdata[C-1:0];
        REG_P2_X: pt[2][AX_X] <= pwdata[C-1:0];
        REG_P2_Y: pt[2][AX_Y] <= pwdata[C-1:0];
        REG_P3_X: pt[3][AX_X] <= pwdata[C-1:0];
        REG_P3_Y: pt[3][AX_Y] <= pwdata[C-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_P0_X: prdata = APB_DATA_W'(pt[0][AX_X]);
      REG_P0_Y: prdata = APB_DATA_W'(pt[0][AX_Y]);
      REG_P1_X: prdata = APB_DATA_W'(pt[1][AX_X]);
      REG_P1_Y: prdata = APB_DATA_W'(pt[1][AX_Y]);
      REG_P2_X: prdata = APB_DATA_W'(pt[2][AX_X]);
      REG_P2_Y: prdata = APB_DATA_W'(pt[2][AX_Y]);
      REG_P3_X: prdata = APB_DATA_W'(pt[3][AX_X]);
      REG_P3_Y: prdata = APB_DATA_W'(pt[3][AX_Y]);
      default:  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   adv;
  logic [NUM_STAGES-1:0] vin;

  always_comb begin
    adv[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
    vin[0] = in_valid;
    for (int i = 1; i < NUM_STAGES; i++) begin
      vin[i] = vld[i-1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vin[i];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic [TW-1:0]  tq    [NUM_STAGES-2];
  logic [TW-1:0]  sq    [NUM_STAGES-2];
  logic [W1P-1:0] prd1s [NUM_AX][3];
  logic [W1P-1:0] prd1t [NUM_AX][3];
  logic [W1-1:0]  lv1   [NUM_AX][3];
  logic [W2P-1:0] prd2s [NUM_AX][2];
  logic [W2P-1:0] prd2t [NUM_AX][2];
  logic [W2-1:0]  lv2   [NUM_AX][2];
  logic [W3P-1:0] prd3s [NUM_AX];
  logic [W3P-1:0] prd3t [NUM_AX];
  logic [TW-1:0]  t_sat;
  logic [W3P-1:0] sum3_x;
  logic [W3P-1:0] sum3_y;

  assign t_sat  = (t_param > T_ONE) ? T_ONE : t_param;
  assign sum3_x = prd3s[AX_X] + prd3t[AX_X];
  assign sum3_y = prd3s[AX_Y] + prd3t[AX_Y];

  always_ff @(posedge clk) begin
    // stage 0: saturate t, form s = 1 - t
    if (adv[0] && vin[0]) begin
      tq[0] <= t_sat;
      sq[0] <= T_ONE - t_sat;
    end
    // carry t and s down the pipe
    for (int i = 1; i < NUM_STAGES - 2; i++) begin
      if (adv[i] && vin[i]) begin
        tq[i] <= tq[i-1];
        sq[i] <= sq[i-1];
      end
    end
    // stage 1: first level products
    if (adv[1] && vin[1]) begin
      for (int a = 0; a < NUM_AX; a++) begin
        for (int k = 0; k < 3; k++) begin
          prd1s[a][k] <= W1P'(sq[0]) * W1P'(pt[k][a]);
          prd1t[a][k] <= W1P'(tq[0]) * W1P'(pt[k+1][a]);
        end
      end
    end
    // stage 2: first level sums, T fraction bits
    if (adv[2] && vin[2]) begin
      for (int a = 0; a < NUM_AX; a++) begin
        for (int k = 0; k < 3; k++) begin
          lv1[a][k] <= W1'(prd1s[a][k] + prd1t[a][k]);
        end
      end
    end
    // stage 3: second level products
    if (adv[3] && vin[3]) begin
      for (int a = 0; a < NUM_AX; a++) begin
        for (int k = 0; k < 2; k++) begin
          prd2s[a][k] <= W2P'(sq[2]) * W2P'(lv1[a][k]);
          prd2t[a][k] <= W2P'(tq[2]) * W2P'(lv1[a][k+1]);
        end
      end
    end
    // stage 4: second level sums, 2T fraction bits
    if (adv[4] && vin[4]) begin
      for (int a = 0; a < NUM_AX; a++) begin
        for (int k = 0; k < 2; k++) begin
          lv2[a][k] <= W2'(prd2s[a][k] + prd2t[a][k]);
        end
      end
    end
    // stage 5: third level products
    if (adv[5] && vin[5]) begin
      for (int a = 0; a < NUM_AX; a++) begin
        prd3s[a] <= W3P'(sq[4]) * W3P'(lv2[a][0]);
        prd3t[a] <= W3P'(tq[4]) * W3P'(lv2[a][1]);
      end
    end
    // stage 6: final sum, drop the 3T fraction bits to floor
    if (adv[6] && vin[6]) begin
      pixel_x <= sum3_x[W3-1:3*T];
      pixel_y <= sum3_y[W3-1:3*T];
    end
  end

endmodule

// File: tb/sv/cbpe_point_checker.sv
// ----------------------------------------------------------------------------
// cbpe_point_checker
// Watches the configuration port and the request and result channels of the
// cubic Bezier point evaluator. Keeps its own copy of the control points, predicts
// the floored curve point for every accepted t, and compares each returned
// point in order against the oldest prediction.
// ----------------------------------------------------------------------------
module cbpe_point_checker
  import cbpe_pkg::*;
#(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic                   pready,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,

  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [T_FRAC_BITS:0]   t_param,

  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [COORD_BITS-1:0]  pixel_x,
  input  logic [COORD_BITS-1:0]  pixel_y,

  output int                     fail_count,
  output int                     pending
);

  localparam int MAX_PRINTS = 40;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  coord_t ctl_x [NUM_PTS];
  coord_t ctl_y [NUM_PTS];
  point_t point_q [$];
  point_t want;

  // Bernstein sum over one axis, exact in 64 bits, then floor
  function automatic coord_t blend_axis(input coord_t c0, input coord_t c1,
                                        input coord_t c2, input coord_t c3,
                                        input longint unsigned t,
                                        input longint unsigned s);
    longint unsigned acc;
    acc = s * s * s * c0 + 3 * t * s * s * c1 + 3 * t * t * s * c2 + t * t * t * c3;
    return coord_t'(acc >> (3 * T_FRAC_BITS));
  endfunction

  function automatic point_t bezier_point(input logic [T_FRAC_BITS:0] t_raw);
    longint unsigned one;
    longint unsigned t;
    longint unsigned s;
    point_t p;
    one = 64'd1 << T_FRAC_BITS;
    // clamp t above one to one
    t = (t_raw > one) ? one : t_raw;
    s = one - t;
    p.x = blend_axis(ctl_x[0], ctl_x[1], ctl_x[2], ctl_x[3], t, s);
    p.y = blend_axis(ctl_y[0], ctl_y[1], ctl_y[2], ctl_y[3], t, s);
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    if (fail_count < MAX_PRINTS) begin
      $display("cbpe_chk: %s expected %0d got %0d at %0t", what, exp_v, got_v, $time);
    end
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        ctl_x[i] = '0;
        ctl_y[i] = '0;
      end
      point_q.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_P0_X: ctl_x[0] = pwdata[COORD_BITS-1:0];
          REG_P0_Y: ctl_y[0] = pwdata[COORD_BITS-1:0];
          REG_P1_X: ctl_x[1] = pwdata[COORD_BITS-1:0];
          REG_P1_Y: ctl_y[1] = pwdata[COORD_BITS-1:0];
          REG_P2_X: ctl_x[2] = pwdata[COORD_BITS-1:0];
          REG_P2_Y: ctl_y[2] = pwdata[COORD_BITS-1:0];
          REG_P3_X: ctl_x[3] = pwdata[COORD_BITS-1:0];
          REG_P3_Y: ctl_y[3] = pwdata[COORD_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        point_q.push_back(bezier_point(t_param));
      end
      if (out_valid && out_ready) begin
        if (point_q.size() == 0) begin
          report_mismatch("point with no request pending, pixel_x", -1, pixel_x);
        end else begin
          want = point_q.pop_front();
          if (pixel_x !== want.x) report_mismatch("pixel_x", want.x, pixel_x);
          if (pixel_y !== want.y) report_mismatch("pixel_y", want.y, pixel_y);
        end
      end
      pending <= point_q.size();
    end
  end

endmodule

// File: tb/sv/cubic_bezier_point_eval_tb.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_tb
// Drives the cubic Bezier point evaluator: programs control points over the
// APB port, sends directed and random t values under several idle and stall
// mixes, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval_tb;
  import cbpe_pkg::*;

  localparam int TW             = T_FRAC_BITS_DEF + 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 16;
  localparam int PHASE_ITEMS    = 105;
  localparam int PAUSE_PHASE    = 6;
  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS_DEF;
  localparam logic [TW-1:0] T_TOP = '1;
  localparam logic [COORD_BITS_DEF-1:0] C_MAX = '1;

  typedef logic [COORD_BITS_DEF-1:0] coord_t;
  typedef coord_t curve_t [NUM_PTS];

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [APB_ADDR_W-1:0]      paddr;
  logic [APB_DATA_W-1:0]      pwdata;
  logic [APB_DATA_W-1:0]      prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_ready;
  logic [TW-1:0]              t_param;
  logic                       out_valid;
  logic                       out_ready;
  logic [COORD_BITS_DEF-1:0]  pixel_x;
  logic [COORD_BITS_DEF-1:0]  pixel_y;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  logic [TW-1:0] sweep_t [12] = '{
    '0, TW'(1), TW'(2), T_ONE - TW'(1), T_ONE, T_ONE + TW'(1), T_TOP, T_ONE >> 1,
    T_ONE >> 2, T_ONE - (T_ONE >> 2), TW'('h0AAA), TW'('h1555)
  };

  cubic_bezier_point_eval u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .t_param   (t_param),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y)
  );

  cbpe_point_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .t_param    (t_param),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // setup then access; psel stays high so writes can run back to back
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input coord_t val);
    logic [APB_DATA_W-1:0] junk;
    junk = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[APB_DATA_W-1:COORD_BITS_DEF], val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_curve(input curve_t cx, input curve_t cy);
    in_valid <= 1'b0;
    wait_drained();
    repeat (NUM_STAGES + 2) @(posedge clk);
    apb_write(REG_P0_X, cx[0]);
    apb_write(REG_P0_Y, cy[0]);
    apb_write(REG_P1_X, cx[1]);
    apb_write(REG_P1_Y, cy[1]);
    apb_write(REG_P2_X, cx[2]);
    apb_write(REG_P2_Y, cy[2]);
    apb_write(REG_P3_X, cx[3]);
    apb_write(REG_P3_Y, cy[3]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_t(input logic [TW-1:0] tv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    t_param  <= tv;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [TW-1:0] pick_t();
    case ($urandom_range(9))
      0:       return ($urandom_range(1)) ? TW'($urandom_range(3)) : T_ONE - TW'($urandom_range(3));
      1:       return T_ONE + TW'(1) + TW'($urandom_range(int'(T_TOP - T_ONE) - 1));
      2:       return TW'($urandom);
      default: return TW'($urandom_range(int'(T_ONE)));
    endcase
  endfunction

  function automatic coord_t pick_coord(input bit ends_only);
    if (ends_only) return ($urandom_range(1)) ? C_MAX : '0;
    case ($urandom_range(7))
      0:       return '0;
      1:       return C_MAX;
      default: return coord_t'($urandom_range(int'(C_MAX)));
    endcase
  endfunction

  initial begin
    curve_t cx;
    curve_t cy;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    t_param        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset control points are all zero
    send_t('0);
    send_t(T_ONE);
    send_t(T_ONE >> 1);

    // zigzag across the full coordinate range
    load_curve('{'0, C_MAX, '0, C_MAX}, '{C_MAX, '0, C_MAX, '0});
    foreach (sweep_t[i]) send_t(sweep_t[i]);

    // all points at the top: the floor must not drop below the maximum
    load_curve('{C_MAX, C_MAX, C_MAX, C_MAX}, '{C_MAX, C_MAX, C_MAX, C_MAX});
    send_t('0);
    send_t(TW'(1));
    send_t(T_ONE - TW'(1));
    send_t(T_ONE);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int i = 0; i < NUM_PTS; i++) begin
        cx[i] = pick_coord(ph % 5 == 4);
        cy[i] = pick_coord(ph % 5 == 4);
      end
      load_curve(cx, cy);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
          // hold off until the pipeline has emptied
          in_valid <= 1'b0;
          wait_drained();
        end
        send_t(pick_t());
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (NUM_STAGES + 5) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
